>>> rtl/amf_pkg.sv
// Shared types and constants of the 5x5 adaptive median filter.
package amf_pkg;

  localparam int WIN          = 5;
  localparam int WIN_AREA     = WIN * WIN;
  localparam int WIN_HALF     = WIN / 2;
  localparam int CENTRE_IDX   = WIN_HALF * WIN + WIN_HALF;
  localparam int LINE_ROWS    = WIN - 1;
  localparam int MED_RANK     = (WIN_AREA - 1) / 2;
  localparam int MIN_DIM      = 5;
  localparam int MAX_HEIGHT   = 256;
  localparam int DEF_MAX_WIDTH = 256;
  localparam int PIX_W        = 8;
  localparam int CFG_W        = 9;
  localparam int CNT_W        = $clog2(WIN_AREA + 1);

  localparam logic [0:0] REG_FRAME_COLS = 1'b0;
  localparam logic [0:0] REG_FRAME_ROWS = 1'b1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 9'd160;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 9'd160;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_pixel;
    logic [7:0]       out_row;
    logic [7:0]       out_col;
    logic             frame_last;
  } out_t;

  // Data handed from one median cell to the next.
  typedef struct packed {
    logic                             valid;
    logic [WIN_AREA-1:0][PIX_W-1:0]   vals;
    logic [WIN_AREA-1:0]              lt;
    logic [WIN_AREA-1:0]              gt;
    logic [CNT_W-1:0]                 nless;
    logic [PIX_W-1:0]                 med;
    logic [PIX_W-1:0]                 centre;
    logic                             keep;
    logic [7:0]                       row;
    logic [7:0]                       col;
    logic                             last;
  } cell_t;

endpackage

>>> rtl/amf_line_store.sv
// Line buffer memory: one word per column holding all buffered rows.
module amf_line_store #(
  parameter int MAX_WIDTH = amf_pkg::DEF_MAX_WIDTH
) (
  input  logic                                            clk,
  input  logic                                            rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                    rd_addr,
  output logic [amf_pkg::LINE_ROWS*amf_pkg::PIX_W-1:0]    rd_data,
  input  logic                                            wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                    wr_addr,
  input  logic [amf_pkg::LINE_ROWS*amf_pkg::PIX_W-1:0]    wr_data
);

  logic [amf_pkg::LINE_ROWS*amf_pkg::PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the column being written in the same cycle returns the new word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

>>> rtl/amf_cell.sv
// One median cell: settles one bit of the window median, MSB first.
module amf_cell #(
  parameter int BIT = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  amf_pkg::cell_t d,
  output amf_pkg::cell_t q
);

  amf_pkg::cell_t               nxt;
  logic [amf_pkg::CNT_W-1:0]    zeros;
  logic [amf_pkg::CNT_W:0]      low_total;
  logic [amf_pkg::WIN_AREA-1:0] open_zero;
  logic [amf_pkg::WIN_AREA-1:0] open_one;

  always_comb begin
    for (int i = 0; i < amf_pkg::WIN_AREA; i++) begin
      open_zero[i] = !d.lt[i] && !d.gt[i] && !d.vals[i][BIT];
      open_one[i]  = !d.lt[i] && !d.gt[i] &&  d.vals[i][BIT];
    end
    zeros = amf_pkg::CNT_W'($countones(open_zero));
    low_total = {1'b0, d.nless} + {1'b0, zeros};
    nxt = d;
    // If enough values sit at or below this bit pattern, the median bit is zero.
    if (low_total > (amf_pkg::CNT_W+1)'(amf_pkg::MED_RANK)) begin
      nxt.med[BIT] = 1'b0;
      nxt.gt       = d.gt | open_one;
    end else begin
      nxt.med[BIT] = 1'b1;
      nxt.lt       = d.lt | open_zero;
      nxt.nless    = low_total[amf_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q.valid <= nxt.valid;
    end
    if (adv) begin
      q.vals   <= nxt.vals;
      q.lt     <= nxt.lt;
      q.gt     <= nxt.gt;
      q.nless  <= nxt.nless;
      q.med    <= nxt.med;
      q.centre <= nxt.centre;
      q.keep   <= nxt.keep;
      q.row    <= nxt.row;
      q.col    <= nxt.col;
      q.last   <= nxt.last;
    end
  end

endmodule

>>> rtl/adaptive_median_filter_5x5.sv
// Top level of the 5x5 adaptive median filter with line buffers and median cells.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   in_data  (pixel_in, frame_start)
//   out      output     out_valid / out_stall out_data (filtered_pixel, out_row,
//                                                       out_col, frame_last)
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// One pixel transfer is taken every clock cycle. A result passes through the stage
// that holds the pixel while the line store is read at its column, then eight
// median cells, each settling one bit of the median. All stages move together;
// they stop only while a result waits at the output and out_stall is high, and
// then in_stall is raised. Synchronous reset clears the position and all valid
// flags; the line store holds no reset value.
module adaptive_median_filter_5x5 #(
  parameter int MAX_WIDTH = amf_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  amf_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output amf_pkg::out_t               out_data,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [amf_pkg::CFG_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  // Extended width for column arithmetic, wide enough for MAX_WIDTH and the register.
  localparam int EW = ((CW + 1) > amf_pkg::CFG_W) ? (CW + 2) : (amf_pkg::CFG_W + 1);
  localparam int HW = amf_pkg::CFG_W + 1;
  localparam int LW = amf_pkg::LINE_ROWS * amf_pkg::PIX_W;
  localparam int PW = amf_pkg::PIX_W;

  // Configuration registers.
  logic [amf_pkg::CFG_W-1:0] frame_cols;
  logic [amf_pkg::CFG_W-1:0] frame_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cols <= amf_pkg::RESET_WIDTH;
      frame_rows <= amf_pkg::RESET_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        amf_pkg::REG_FRAME_COLS: frame_cols <= cfg_data;
        amf_pkg::REG_FRAME_ROWS: frame_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // The sizes in effect are the registers saturated into their legal ranges.
  logic [EW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (EW'(frame_cols) < EW'(amf_pkg::MIN_DIM)) begin
      w_eff = EW'(amf_pkg::MIN_DIM);
    end else if (EW'(frame_cols) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(frame_cols);
    end
    if (HW'(frame_rows) < HW'(amf_pkg::MIN_DIM)) begin
      h_eff = HW'(amf_pkg::MIN_DIM);
    end else if (HW'(frame_rows) > HW'(amf_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(amf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_rows);
    end
  end

  // The whole pipeline moves unless a finished result is held at the output.
  logic adv;
  logic accept;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Raster position of the next pixel.
  logic [CW-1:0] col_count;
  logic [7:0]    row_count;
  logic [CW-1:0] col_count_next;
  logic [7:0]    row_count_next;
  logic [EW-1:0] c_start;
  logic [EW-1:0] c_cur;
  logic [HW-1:0] r_start;
  logic [HW-1:0] r_cur;
  logic          cur_emit;
  logic          cur_last;

  always_comb begin
    if (in_data.frame_start) begin
      c_start = '0;
      r_start = '0;
    end else begin
      c_start = EW'(col_count);
      r_start = HW'(row_count);
    end
    // A position beyond the current size wraps before the pixel is taken.
    if (c_start >= w_eff) begin
      c_cur = '0;
      r_cur = r_start + HW'(1);
    end else begin
      c_cur = c_start;
      r_cur = r_start;
    end
    if (r_cur >= h_eff) begin
      r_cur = '0;
    end
    if ((c_cur + EW'(1)) >= w_eff) begin
      col_count_next = '0;
      if ((r_cur + HW'(1)) >= h_eff) begin
        row_count_next = '0;
      end else begin
        row_count_next = 8'(r_cur + HW'(1));
      end
    end else begin
      col_count_next = CW'(c_cur + EW'(1));
      row_count_next = r_cur[7:0];
    end
    cur_emit = (r_cur >= HW'(amf_pkg::WIN - 1)) && (c_cur >= EW'(amf_pkg::WIN - 1));
    cur_last = (r_cur == (h_eff - HW'(1))) && (c_cur == (w_eff - EW'(1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Stage one holds the pixel while the line store is read at its column.
  logic          s1_valid;
  logic [PW-1:0] s1_pix;
  logic [CW-1:0] s1_col;
  logic [7:0]    s1_orow;
  logic [7:0]    s1_ocol;
  logic          s1_emit;
  logic          s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= in_data.pixel_in;
      s1_col  <= c_cur[CW-1:0];
      s1_orow <= 8'(r_cur - HW'(amf_pkg::WIN_HALF));
      s1_ocol <= 8'(c_cur - EW'(amf_pkg::WIN_HALF));
      s1_emit <= cur_emit;
      s1_last <= cur_last;
    end
  end

  logic [LW-1:0] line_rd;
  logic [LW-1:0] line_wr;
  logic          line_we;

  // Every buffered row moves up by one; the new pixel enters the bottom row.
  assign line_wr = {s1_pix, line_rd[LW-1:PW]};
  assign line_we = adv && s1_valid;

  amf_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c_cur[CW-1:0]),
    .rd_data (line_rd),
    .wr_en   (line_we),
    .wr_addr (s1_col),
    .wr_data (line_wr)
  );

  // The 5x5 window shifts left and takes the new column on the right.
  logic [amf_pkg::WIN_AREA-1:0][PW-1:0] window_regs;
  logic [amf_pkg::WIN_AREA-1:0][PW-1:0] window_next;
  logic [PW-1:0]                        centre;
  logic                                 any_lt;
  logic                                 any_gt;

  always_comb begin
    for (int y = 0; y < amf_pkg::WIN; y++) begin
      for (int x = 0; x < amf_pkg::WIN - 1; x++) begin
        window_next[y*amf_pkg::WIN + x] = window_regs[y*amf_pkg::WIN + x + 1];
      end
      if (y < amf_pkg::LINE_ROWS) begin
        window_next[y*amf_pkg::WIN + amf_pkg::WIN - 1] = line_rd[y*PW +: PW];
      end else begin
        window_next[y*amf_pkg::WIN + amf_pkg::WIN - 1] = s1_pix;
      end
    end
    centre = window_next[amf_pkg::CENTRE_IDX];
    // The centre stays when some value lies below it and some above it.
    any_lt = 1'b0;
    any_gt = 1'b0;
    for (int i = 0; i < amf_pkg::WIN_AREA; i++) begin
      any_lt = any_lt | (window_next[i] < centre);
      any_gt = any_gt | (window_next[i] > centre);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_regs <= '0;
    end else if (line_we) begin
      window_regs <= window_next;
    end
  end

  // Chain of median cells, one per pixel bit, most significant bit first.
  amf_pkg::cell_t chain [PW+1];

  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = s1_valid && s1_emit;
    chain[0].vals   = window_next;
    chain[0].centre = centre;
    chain[0].keep   = any_lt && any_gt;
    chain[0].row    = s1_orow;
    chain[0].col    = s1_ocol;
    chain[0].last   = s1_last;
  end

  for (genvar b = 0; b < PW; b++) begin : g_cell
    amf_cell #(
      .BIT(PW - 1 - b)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (chain[b]),
      .q   (chain[b+1])
    );
  end

  // The last cell's register is the output register.
  assign out_valid               = chain[PW].valid;
  assign out_data.filtered_pixel = chain[PW].keep ? chain[PW].centre : chain[PW].med;
  assign out_data.out_row        = chain[PW].row;
  assign out_data.out_col        = chain[PW].col;
  assign out_data.frame_last     = chain[PW].last;

  // Input is held back only because a result is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // An interior pixel always enters the median chain.
  a_emit_enters: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && s1_emit) |=> chain[1].valid)
    else $error("interior pixel lost before the median cells");

  // A border position never produces a result.
  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.out_row >= 8'd2) && (out_data.out_col >= 8'd2)))
    else $error("result for a border position");

  // The count of values below the median never exceeds the median rank.
  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chain[PW].nless <= amf_pkg::CNT_W'(amf_pkg::MED_RANK)))
    else $error("median rank count out of range");

endmodule
